/* sv/bfvt_pkg.sv */
// Shared types and constants for the box frustum visibility test.
package bfvt_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int IDX_BITS    = 3;

    // Register indexes of the configuration port
    localparam logic [IDX_BITS-1:0] REG_TOP    = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_BOTTOM = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_RIGHT  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_LEFT   = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_FAR    = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_NEAR   = 3'd5;

    localparam int PT_BITS   = 26;  // point coordinate, room for lo + MAX_SPAN + step
    localparam int PROD_BITS = 42;  // 16 x 26 signed product
    localparam int DIST_BITS = 45;  // sum of three products and the offset term

    typedef logic [63:0] t_plane;

    // Point handed to the plane pipeline
    typedef struct packed {
        logic                       valid;
        logic                       last;
        logic signed [PT_BITS-1:0]  x;
        logic signed [PT_BITS-1:0]  y;
        logic signed [PT_BITS-1:0]  z;
    } t_point;

endpackage

/* sv/bfvt_plane_pipe.sv */
// Three-stage plane evaluation: multiply, sum, compare against all six planes.
module bfvt_plane_pipe (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  bfvt_pkg::t_plane                   i_planes [bfvt_pkg::PLANE_COUNT],
    input  bfvt_pkg::t_point                   i_pt,
    output logic                               o_valid,
    output logic                               o_last,
    output logic                               o_inside
);
    localparam int PC = bfvt_pkg::PLANE_COUNT;
    localparam int PB = bfvt_pkg::PROD_BITS;
    localparam int DB = bfvt_pkg::DIST_BITS;

    logic signed [PB-1:0] r_px [PC];
    logic signed [PB-1:0] r_py [PC];
    logic signed [PB-1:0] r_pz [PC];
    logic signed [PB-1:0] r_po [PC];
    logic signed [DB-1:0] r_d  [PC];
    logic [2:0]           r_v;
    logic [2:0]           r_l;
    logic                 r_in;
    logic                 pass_all;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_l <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[1:0], i_pt.valid};
            r_l <= {r_l[1:0], i_pt.last};
        end
    end

    always_comb begin
        pass_all = 1'b1;
        for (int i = 0; i < PC; i++)
            if (r_d[i][DB-1] || r_d[i] == '0) pass_all = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < PC; i++) begin
                r_px[i] <= PB'($signed(i_planes[i][15:0]) * i_pt.x);
                r_py[i] <= PB'($signed(i_planes[i][31:16]) * i_pt.y);
                r_pz[i] <= PB'($signed(i_planes[i][47:32]) * i_pt.z);
                r_po[i] <= PB'({{(PB-30){i_planes[i][63]}}, i_planes[i][63:48], 14'd0});
                r_d[i]  <= DB'(r_px[i]) + DB'(r_py[i]) + DB'(r_pz[i]) - DB'(r_po[i]);
            end
            r_in <= pass_all;
        end
    end

    assign o_valid  = r_v[2];
    assign o_last   = r_l[2];
    assign o_inside = r_in;
endmodule

/* sv/bfvt_point_gen.sv */
// Point sequencer: eight corners, then the clamped grid in x, y, z order.
module bfvt_point_gen #(
    parameter int GRID_STEP  = 4,
    parameter int MAX_SPAN   = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_adv,
    input  logic                   i_stop,
    input  logic signed [15:0]     i_lo [3],
    input  logic signed [15:0]     i_hi [3],
    output logic                   o_busy,
    output logic                   o_clamped,
    output bfvt_pkg::t_point       o_pt
);
    localparam int PT = bfvt_pkg::PT_BITS;

    logic signed [PT-1:0] r_lo [3];
    logic signed [PT-1:0] r_hi [3];
    logic signed [PT-1:0] r_end [3];
    logic signed [PT-1:0] r_x, r_y, r_z;
    logic [2:0]           r_corner;
    logic                 r_grid;
    logic                 r_busy;

    logic signed [PT-1:0] lo_ext [3];
    logic signed [PT-1:0] hi_ext [3];
    logic [2:0]           clamp;
    logic signed [PT-1:0] nx, ny, nz;
    logic                 grid_empty, x_done, y_done, z_done;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo_ext[a] = PT'($signed(i_lo[a][COORD_BITS-1:0]));
            hi_ext[a] = PT'($signed(i_hi[a][COORD_BITS-1:0]));
            clamp[a]  = (hi_ext[a] - lo_ext[a]) > PT'(MAX_SPAN);
        end
    end

    assign nx = r_x + PT'(GRID_STEP);
    assign ny = r_y + PT'(GRID_STEP);
    assign nz = r_z + PT'(GRID_STEP);
    assign z_done = nz > r_end[2];
    assign y_done = ny > r_end[1];
    assign x_done = nx > r_end[0];
    assign grid_empty = (r_end[0] < r_lo[0]) || (r_end[1] < r_lo[1]) || (r_end[2] < r_lo[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (i_stop || (i_adv && o_pt.last)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a]  <= lo_ext[a];
                r_hi[a]  <= hi_ext[a];
                r_end[a] <= clamp[a] ? lo_ext[a] + PT'(MAX_SPAN) : hi_ext[a];
            end
            o_clamped <= |clamp;
            r_corner  <= '0;
            r_grid    <= 1'b0;
        end else if (i_adv && r_busy) begin
            if (!r_grid) begin
                r_corner <= r_corner + 3'd1;
                if (r_corner == 3'd7) begin
                    r_grid <= 1'b1;
                    r_x    <= r_lo[0];
                    r_y    <= r_lo[1];
                    r_z    <= r_lo[2];
                end
            end else if (!z_done) begin
                r_z <= nz;
            end else begin
                r_z <= r_lo[2];
                if (!y_done) begin
                    r_y <= ny;
                end else begin
                    r_y <= r_lo[1];
                    r_x <= nx;
                end
            end
        end
    end

    always_comb begin
        o_pt.valid = r_busy && !i_stop;
        if (!r_grid) begin
            o_pt.x    = r_corner[0] ? r_hi[0] : r_lo[0];
            o_pt.y    = r_corner[1] ? r_hi[1] : r_lo[1];
            o_pt.z    = r_corner[2] ? r_hi[2] : r_lo[2];
            o_pt.last = (r_corner == 3'd7) && grid_empty;
        end else begin
            o_pt.x    = r_x;
            o_pt.y    = r_y;
            o_pt.z    = r_z;
            o_pt.last = z_done && y_done && x_done;
        end
    end

    assign o_busy = r_busy;
endmodule

/* sv/box_frustum_visibility_test.sv */
// Top level of the box frustum visibility test.
// Usage: present a box (lo/hi corners) on the input channel; one result
// (visible, span_clamped) comes back on the output channel per box.
// The six plane registers sit on the APB port at 8*i and may be written
// only while the block is idle; they reset to zero, which rejects all points.
// One box is worked on at a time. The point sequencer issues one point per
// cycle (eight corners, then up to 5x5x5 grid points at default settings)
// into a three-stage plane pipeline; the first inside point ends the scan.
// Points in flight after a hit are dropped. The result register holds while
// the receiver stalls; the next box is accepted once the result is taken.
// Reset clears the pipeline, the sequencer and the output valid.
module box_frustum_visibility_test #(
    parameter int GRID_STEP  = 4,
    parameter int MAX_SPAN   = 16,
    parameter int COORD_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_lo_x,
    input  logic signed [15:0] i_lo_y,
    input  logic signed [15:0] i_lo_z,
    input  logic signed [15:0] i_hi_x,
    input  logic signed [15:0] i_hi_y,
    input  logic signed [15:0] i_hi_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_visible,
    output logic               o_span_clamped,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    bfvt_pkg::t_plane r_planes [bfvt_pkg::PLANE_COUNT];
    logic [bfvt_pkg::IDX_BITS-1:0] reg_idx;
    logic r_active, r_hit, r_flush;
    logic start, pg_busy, pg_clamped;
    logic pp_valid, pp_last, pp_inside, done;
    logic signed [15:0] lo [3];
    logic signed [15:0] hi [3];
    bfvt_pkg::t_point pt;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bfvt_pkg::PLANE_COUNT; i++) r_planes[i] <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                bfvt_pkg::REG_TOP:    r_planes[0] <= pwdata;
                bfvt_pkg::REG_BOTTOM: r_planes[1] <= pwdata;
                bfvt_pkg::REG_RIGHT:  r_planes[2] <= pwdata;
                bfvt_pkg::REG_LEFT:   r_planes[3] <= pwdata;
                bfvt_pkg::REG_FAR:    r_planes[4] <= pwdata;
                bfvt_pkg::REG_NEAR:   r_planes[5] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bfvt_pkg::REG_TOP:    prdata = r_planes[0];
            bfvt_pkg::REG_BOTTOM: prdata = r_planes[1];
            bfvt_pkg::REG_RIGHT:  prdata = r_planes[2];
            bfvt_pkg::REG_LEFT:   prdata = r_planes[3];
            bfvt_pkg::REG_FAR:    prdata = r_planes[4];
            bfvt_pkg::REG_NEAR:   prdata = r_planes[5];
            default:              prdata = '0;
        endcase
    end

    assign lo[0] = i_lo_x; assign lo[1] = i_lo_y; assign lo[2] = i_lo_z;
    assign hi[0] = i_hi_x; assign hi[1] = i_hi_y; assign hi[2] = i_hi_z;

    assign o_ready = !r_active && !o_valid;
    assign start   = i_valid && o_ready;

    // a hit or the last point closes the box
    assign done = r_active && pp_valid && !r_flush && (pp_inside || pp_last);

    bfvt_point_gen #(
        .GRID_STEP  (GRID_STEP),
        .MAX_SPAN   (MAX_SPAN),
        .COORD_BITS (COORD_BITS)
    ) u_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_adv     (1'b1),
        .i_stop    (r_hit || (pp_valid && pp_inside)),
        .i_lo      (lo),
        .i_hi      (hi),
        .o_busy    (pg_busy),
        .o_clamped (pg_clamped),
        .o_pt      (pt)
    );

    bfvt_plane_pipe u_pipe (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (1'b1),
        .i_planes (r_planes),
        .i_pt     (pt),
        .o_valid  (pp_valid),
        .o_last   (pp_last),
        .o_inside (pp_inside)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_hit    <= 1'b0;
            r_flush  <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            if (start) begin
                r_active <= 1'b1;
                r_hit    <= 1'b0;
                r_flush  <= 1'b0;
            end else if (done) begin
                r_active <= 1'b0;
                r_hit    <= 1'b1;
                r_flush  <= 1'b1;
            end else if (!pg_busy && !pp_valid) begin
                // drain stragglers after a hit
                r_flush <= 1'b0;
                r_hit   <= 1'b0;
            end
            if (done) begin
                o_valid        <= 1'b1;
                o_visible      <= pp_inside;
                o_span_clamped <= pg_clamped;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
    end
endmodule

/* sim/box_frustum_visibility_test_test.sv */
// Testbench for the box frustum visibility test: plane setups, directed and random boxes.
module box_frustum_visibility_test_test;

    localparam int STEP       = 4;
    localparam int SPAN       = 16;
    localparam int WDOG_LIMIT = 20000;
    localparam int IDXW       = bfvt_pkg::IDX_BITS;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic signed [15:0] i_lo_x, i_lo_y, i_lo_z, i_hi_x, i_hi_y, i_hi_z;
    logic              o_valid;
    logic              i_ready;
    logic              o_visible;
    logic              o_span_clamped;
    logic              psel, penable, pwrite;
    logic [5:0]        paddr;
    logic [63:0]       pwdata;
    logic [63:0]       prdata;
    logic              pready;

    box_frustum_visibility_test dut (.*);

    typedef struct {
        logic vis;
        logic clamp;
    } t_verdict;

    bfvt_pkg::t_plane plane_regs[bfvt_pkg::PLANE_COUNT];
    t_verdict verdict_q[$];
    int       n_errors;
    int       n_boxes;
    int       n_results;
    int       n_visible;
    int       n_clamped;
    int       idle_cycles;
    int       stall_mode;
    int       burst_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic plane_pass(bfvt_pkg::t_plane p, longint x, longint y, longint z);
        longint nx, ny, nz, off, d;
        begin
            nx  = longint'($signed(p[15:0]));
            ny  = longint'($signed(p[31:16]));
            nz  = longint'($signed(p[47:32]));
            off = longint'($signed(p[63:48]));
            d = nx * x + ny * y + nz * z - off * 16384;
            return d > 0;
        end
    endfunction

    function automatic logic point_in_frustum(longint x, longint y, longint z);
        begin
            for (int i = 0; i < bfvt_pkg::PLANE_COUNT; i++)
                if (!plane_pass(plane_regs[i], x, y, z))
                    return 1'b0;
            return 1'b1;
        end
    endfunction

    function automatic t_verdict predict_visibility(logic signed [15:0] lx, logic signed [15:0] ly,
                                                   logic signed [15:0] lz, logic signed [15:0] hx,
                                                   logic signed [15:0] hy, logic signed [15:0] hz);
        longint lo[3], hi[3], lim[3];
        t_verdict v;
        begin
            lo[0] = lx; lo[1] = ly; lo[2] = lz;
            hi[0] = hx; hi[1] = hy; hi[2] = hz;
            v.vis = 1'b0;
            v.clamp = 1'b0;
            for (int a = 0; a < 3; a++) begin
                if (hi[a] - lo[a] > SPAN) begin
                    v.clamp = 1'b1;
                    lim[a] = lo[a] + SPAN;
                end else begin
                    lim[a] = hi[a];
                end
            end
            for (int c = 0; c < 8 && !v.vis; c++)
                v.vis = point_in_frustum(c[0] ? hi[0] : lo[0], c[1] ? hi[1] : lo[1],
                                         c[2] ? hi[2] : lo[2]);
            for (longint x = lo[0]; x <= lim[0] && !v.vis; x += STEP)
                for (longint y = lo[1]; y <= lim[1] && !v.vis; y += STEP)
                    for (longint z = lo[2]; z <= lim[2] && !v.vis; z += STEP)
                        v.vis = point_in_frustum(x, y, z);
            return v;
        end
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        begin
            $display("mismatch %0s at result %0d: got %0d want %0d", what, n_results, got, want);
            n_errors++;
        end
    endtask

    // result checker and receiver stall pattern
    always @(posedge i_clk) begin
        t_verdict e;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdict_q.size() == 0) begin
                $display("unexpected result %0d", n_results);
                n_errors++;
            end else begin
                e = verdict_q.pop_front();
                if (o_visible !== e.vis) report_mismatch("visible", o_visible, e.vis);
                if (o_span_clamped !== e.clamp)
                    report_mismatch("span_clamped", o_span_clamped, e.clamp);
                if (e.vis) n_visible++;
                if (e.clamp) n_clamped++;
            end
            n_results++;
        end
    end

    always @(negedge i_clk) begin
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= ($urandom_range(0, 9) < 2);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("watchdog expired");
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_plane(logic [IDXW-1:0] idx, bfvt_pkg::t_plane val);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 3'b000};
            pwdata  <= val;
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            if (idx < bfvt_pkg::PLANE_COUNT) plane_regs[idx] = val;
            @(negedge i_clk);
        end
    endtask

    task automatic drain;
        begin
            i_valid <= 1'b0;
            while (verdict_q.size() != 0) @(negedge i_clk);
            repeat (160) @(negedge i_clk);
        end
    endtask

    // Send one box; called at a falling edge, returns at a falling edge.
    task automatic send_box(logic signed [15:0] lx, logic signed [15:0] ly, logic signed [15:0] lz,
                            logic signed [15:0] hx, logic signed [15:0] hy, logic signed [15:0] hz);
        int gap;
        begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            i_valid <= 1'b1;
            i_lo_x <= lx; i_lo_y <= ly; i_lo_z <= lz;
            i_hi_x <= hx; i_hi_y <= hy; i_hi_z <= hz;
            verdict_q.push_back(predict_visibility(lx, ly, lz, hx, hy, hz));
            @(posedge i_clk);
            while (!o_ready) @(posedge i_clk);
            @(negedge i_clk);
            n_boxes++;
        end
    endtask

    // Planes bounding roughly a cube around the origin of half width hw.
    task automatic load_cube(int hw);
        begin
            write_plane(bfvt_pkg::REG_TOP,    {16'(-hw), 16'h0000, 16'hC000, 16'h0000});
            write_plane(bfvt_pkg::REG_BOTTOM, {16'(-hw), 16'h0000, 16'h4000, 16'h0000});
            write_plane(bfvt_pkg::REG_RIGHT,  {16'(-hw), 16'h0000, 16'h0000, 16'hC000});
            write_plane(bfvt_pkg::REG_LEFT,   {16'(-hw), 16'h0000, 16'h0000, 16'h4000});
            write_plane(bfvt_pkg::REG_FAR,    {16'(-hw), 16'hC000, 16'h0000, 16'h0000});
            write_plane(bfvt_pkg::REG_NEAR,   {16'(-hw), 16'h4000, 16'h0000, 16'h0000});
        end
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 160)) - 80);
        endcase
    endfunction

    task automatic random_box;
        logic signed [15:0] l[3];
        logic signed [15:0] h[3];
        begin
            for (int a = 0; a < 3; a++) begin
                l[a] = rand_coord();
                case ($urandom_range(0, 9))
                    0: h[a] = rand_coord();
                    1: h[a] = l[a] - 16'($urandom_range(1, 8));
                    2: h[a] = l[a] + 16'($urandom_range(17, 60));
                    default: h[a] = l[a] + 16'($urandom_range(0, 16));
                endcase
            end
            send_box(l[0], l[1], l[2], h[0], h[1], h[2]);
        end
    endtask

    task automatic test_reset_planes;
        begin
            send_box(0, 0, 0, 4, 4, 4);
            send_box(16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff);
            drain();
        end
    endtask

    task automatic test_directed_cube;
        begin
            load_cube(20);
            send_box(-4, -4, -4, 4, 4, 4);           // inside
            send_box(100, 100, 100, 110, 110, 110);  // outside
            send_box(-30, -30, -30, 30, 30, 30);     // corners out, grid hits, clamped
            send_box(-60, -2, -2, -21, 2, 2);        // clamped, wholly outside in x
            send_box(5, 5, 5, -5, -5, -5);           // inverted, corners in
            send_box(50, 0, 0, 40, 0, 0);            // inverted and outside
            send_box(-20, 0, 0, -20, 0, 0);          // on a plane, not inside
            send_box(-19, 0, 0, -19, 0, 0);
            send_box(16'sh8000, 0, 0, 16'sh7fff, 0, 0);
            send_box(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000);
            send_box(-25, -25, -25, -9, -9, -9);     // span exactly at limit
            send_box(-26, -26, -26, -9, -9, -9);
            drain();
        end
    endtask

    task automatic test_extreme_planes;
        begin
            write_plane(bfvt_pkg::REG_TOP,    64'hffff_ffff_ffff_ffff);
            write_plane(bfvt_pkg::REG_BOTTOM, 64'h8000_7fff_7fff_7fff);
            write_plane(bfvt_pkg::REG_RIGHT,  64'h7fff_8000_8000_8000);
            write_plane(bfvt_pkg::REG_LEFT,   64'h8000_0001_0001_0001);
            write_plane(bfvt_pkg::REG_FAR,    64'h8000_4000_4000_4000);
            write_plane(bfvt_pkg::REG_NEAR,   64'h8000_0000_0000_0000);
            for (int i = 0; i < 12; i++) random_box();
            drain();
        end
    endtask

    task automatic test_random_planes;
        begin
            for (int r = 0; r < bfvt_pkg::PLANE_COUNT; r++)
                write_plane(IDXW'(r), {$urandom, $urandom});
            for (int i = 0; i < 150; i++) random_box();
            drain();
        end
    endtask

    task automatic test_random_cubes;
        begin
            for (int s = 0; s < 7; s++) begin
                load_cube($urandom_range(1, 90));
                for (int i = 0; i < 150; i++) random_box();
                drain();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        {i_lo_x, i_lo_y, i_lo_z, i_hi_x, i_hi_y, i_hi_z} = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        n_errors = 0; n_boxes = 0; n_results = 0; n_visible = 0; n_clamped = 0;
        idle_cycles = 0; stall_mode = 0; burst_left = 0;
        for (int i = 0; i < bfvt_pkg::PLANE_COUNT; i++) plane_regs[i] = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_planes();
        test_directed_cube();
        test_extreme_planes();
        test_random_planes();
        test_random_cubes();
        load_cube(40);
        for (int i = 0; i < 20; i++) random_box();
        drain();
        $display("covered %0d boxes, %0d results: %0d visible, %0d clamped",
                 n_boxes, n_results, n_visible, n_clamped);
        $display("plane sets: reset, extreme, random, and nine cube sizes");
        if (n_errors == 0 && verdict_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
